// File: hdl/expiry_ordered_timer_table_assert.svh
// Assertion macros used by the timer table RTL.
`ifndef EXPIRY_ORDERED_TIMER_TABLE_ASSERT_SVH
`define EXPIRY_ORDERED_TIMER_TABLE_ASSERT_SVH

// Check cons in the same cycle as ante.
`define EOT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timer table check failed");

// Check cons in the cycle after ante.
`define EOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timer table check failed");

`endif

// File: hdl/eot_pkg.sv
package eot_pkg;

  localparam int TIMER_SLOTS_DEF = 32;
  localparam int MAX_RESULTS     = 32;

  localparam int FUNC_W = 2;
  localparam int ID_W   = 16;
  localparam int TMO_W  = 31;
  localparam int TIME_W = 32;
  localparam int STAT_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADJUST = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EXPIRED  = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd4;

  typedef logic [TIME_W-1:0] time_ms_t;
  typedef logic [ID_W-1:0]   timer_id_t;

  // true when a lies strictly after b on the wrapping time line
  function automatic logic time_after(time_ms_t a, time_ms_t b);
    time_ms_t d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

// File: hdl/eot_in_if.sv
interface eot_in_if;
  import eot_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [ID_W-1:0]       timer_id;
  logic [TMO_W-1:0]      timeout_ms;
  logic [TIME_W-1:0]     now_ms;

  modport source (output valid, func, timer_id, timeout_ms, now_ms, input ready);
  modport sink   (input valid, func, timer_id, timeout_ms, now_ms, output ready);
endinterface

// File: hdl/eot_out_if.sv
interface eot_out_if;
  import eot_pkg::*;

  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   expired_id;
  logic              last;

  modport source (output valid, status, expired_id, last, input ready);
  modport sink   (input valid, status, expired_id, last, output ready);
endinterface

// File: hdl/expiry_ordered_timer_table.sv
// Timer table kept sorted by expiry time, up to TIMER_SLOTS timers.
// in_ch carries one command: add, adjust, remove or tick, with id, timeout
// and current time. out_ch returns results; each carries last on the final
// result of its command. Add, adjust and remove give one result each; tick
// gives one expired result per due timer, in expiry order, at most 32 per
// tick, or a single nothing-expired result.
// All work goes through one single-port-read table memory and one wrapping
// time comparator; every table step is a read state followed by a
// compare/write state. Add moves later entries up; remove searches for the
// id and moves the entries behind it down; adjust does both; tick scans the
// due entries, then moves the rest down. in_ch.ready is high only between
// commands. One output register holds a result; while the receiver stalls,
// the sequencer waits before producing the next result and nothing is lost.
// Reset (synchronous, rst_n low) empties the table at once; no clearing pass
// is needed since only live entries are ever read.
module expiry_ordered_timer_table #(
  parameter int TIMER_SLOTS = eot_pkg::TIMER_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  eot_in_if.sink    in_ch,
  eot_out_if.source out_ch
);
  import eot_pkg::*;

  `include "expiry_ordered_timer_table_assert.svh"

  localparam int AW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int EW = TIME_W + ID_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(TIMER_SLOTS);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_EV  = 4'd2;
  localparam logic [3:0] S_FIND_RD = 4'd3;
  localparam logic [3:0] S_FIND_EV = 4'd4;
  localparam logic [3:0] S_SHF_RD  = 4'd5;
  localparam logic [3:0] S_SHF_WR  = 4'd6;
  localparam logic [3:0] S_SCAN_RD = 4'd7;
  localparam logic [3:0] S_SCAN_EV = 4'd8;
  localparam logic [3:0] S_SCAN_END = 4'd9;
  localparam logic [3:0] S_RESP    = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  timer_id_t         id_r, id_nxt;
  time_ms_t          exp_r, exp_nxt;
  time_ms_t          now_r, now_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     dist_r, dist_nxt;
  logic              pend_r, pend_nxt;
  timer_id_t         pend_id_r, pend_id_nxt;
  logic [STAT_W-1:0] res_r, res_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  timer_id_t         out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [CW-1:0] ptr_m1, wr_pos;
  time_ms_t      rd_exp, cmp_b;
  timer_id_t     rd_own;
  logic          after;
  logic          emit_ok;
  logic          accept;

  eot_ram #(.WIDTH(EW), .DEPTH(TIMER_SLOTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_exp  = rdata[EW-1:ID_W];
  assign rd_own  = rdata[ID_W-1:0];
  assign cmp_b   = (state_r == S_SCAN_EV) ? now_r : exp_r;
  assign after   = time_after(rd_exp, cmp_b);
  assign ptr_m1  = ptr_r - 1'b1;
  assign wr_pos  = ptr_r - dist_r;
  assign emit_ok = !out_valid_r || out_ch.ready;
  assign accept  = in_ch.valid && in_ch.ready;

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.expired_id = out_id_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    state_nxt   = state_r;
    func_nxt    = func_r;
    id_nxt      = id_r;
    exp_nxt     = exp_r;
    now_nxt     = now_r;
    count_nxt   = count_r;
    ptr_nxt     = ptr_r;
    dist_nxt    = dist_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    res_nxt     = res_r;

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_last_nxt   = out_last_r;

    we    = 1'b0;
    waddr = ptr_r[AW-1:0];
    wdata = {exp_r, id_r};
    raddr = ptr_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt = in_ch.func;
          id_nxt   = in_ch.timer_id;
          exp_nxt  = in_ch.now_ms + TIME_W'(in_ch.timeout_ms);
          now_nxt  = in_ch.now_ms;
          pend_nxt = 1'b0;
          ptr_nxt  = '0;
          case (in_ch.func)
            FUNC_ADD: begin
              if (count_r == SLOTS_C) begin
                res_nxt   = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                ptr_nxt   = count_r;
                state_nxt = S_INS_RD;
              end
            end
            FUNC_ADJUST, FUNC_REMOVE: state_nxt = S_FIND_RD;
            FUNC_TICK:                state_nxt = S_SCAN_RD;
            default:                  state_nxt = S_IDLE;
          endcase
        end
      end
      S_INS_RD: begin
        raddr = ptr_m1[AW-1:0];
        if (ptr_r == '0) begin
          we        = 1'b1;
          count_nxt = count_r + 1'b1;
          res_nxt   = ST_OK;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_INS_EV;
        end
      end
      S_INS_EV: begin
        raddr = ptr_m1[AW-1:0];
        we    = 1'b1;
        if (after) begin
          wdata     = rdata;
          ptr_nxt   = ptr_m1;
          state_nxt = S_INS_RD;
        end else begin
          count_nxt = count_r + 1'b1;
          res_nxt   = ST_OK;
          state_nxt = S_RESP;
        end
      end
      S_FIND_RD: begin
        if (ptr_r == count_r) begin
          res_nxt   = ST_NOTFOUND;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_FIND_EV;
        end
      end
      S_FIND_EV: begin
        ptr_nxt = ptr_r + 1'b1;
        if (rd_own == id_r) begin
          dist_nxt  = CW'(1);
          state_nxt = S_SHF_RD;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_SHF_RD: begin
        if (ptr_r == count_r) begin
          count_nxt = count_r - dist_r;
          case (func_r)
            FUNC_ADJUST: begin
              ptr_nxt   = count_r - dist_r;
              state_nxt = S_INS_RD;
            end
            FUNC_REMOVE: begin
              res_nxt   = ST_OK;
              state_nxt = S_RESP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end else begin
          state_nxt = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        we        = 1'b1;
        waddr     = wr_pos[AW-1:0];
        wdata     = rdata;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_SHF_RD;
      end
      S_SCAN_RD: begin
        if (ptr_r == count_r || int'(ptr_r) == MAX_RESULTS) begin
          state_nxt = S_SCAN_END;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (after) begin
          state_nxt = S_SCAN_END;
        end else if (!pend_r || emit_ok) begin
          if (pend_r) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_EXPIRED;
            out_id_nxt     = pend_id_r;
            out_last_nxt   = 1'b0;
          end
          pend_nxt    = 1'b1;
          pend_id_nxt = rd_own;
          ptr_nxt     = ptr_r + 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SCAN_END: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_r ? ST_EXPIRED : ST_NONE;
          out_id_nxt     = pend_r ? pend_id_r : '0;
          out_last_nxt   = 1'b1;
          pend_nxt       = 1'b0;
          if (pend_r) begin
            dist_nxt  = ptr_r;
            state_nxt = S_SHF_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_id_nxt     = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    id_r         <= id_nxt;
    exp_r        <= exp_nxt;
    now_r        <= now_nxt;
    ptr_r        <= ptr_nxt;
    dist_r       <= dist_nxt;
    pend_id_r    <= pend_id_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_last_r   <= out_last_nxt;
  end

  `EOT_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_r <= SLOTS_C)
  `EOT_ASSERT_NEXT(a_full_add, clk, rst_n,
    accept && in_ch.func == FUNC_ADD && count_r == SLOTS_C,
    state_r == S_RESP && res_r == ST_FULL)
  `EOT_ASSERT_SAME(a_shift_dist, clk, rst_n,
    state_r == S_SHF_RD || state_r == S_SHF_WR, dist_r != '0)
  `EOT_ASSERT_SAME(a_idle_no_pend, clk, rst_n, state_r == S_IDLE, !pend_r)

endmodule

// File: hdl/eot_ram.sv
module eot_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tb_top.sv
module tb_top;
  import eot_pkg::*;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    timer_id_t         expired_id;
    logic              last;
  } timer_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  eot_in_if  in_ch ();
  eot_out_if out_ch ();

  expiry_ordered_timer_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the timer table
  time_ms_t  slot_expiry [TIMER_SLOTS_DEF];
  timer_id_t slot_owner  [TIMER_SLOTS_DEF];
  int        live_count = 0;

  timer_reply_t predicted_replies[$];

  int       in_idle_pct   = 0;
  int       out_stall_pct = 0;
  time_ms_t wall_ms       = '0;

  int cmds_sent       = 0;
  int cmd_count[4]    = '{0, 0, 0, 0};
  int replies_checked = 0;
  int mismatch_count  = 0;
  int full_seen       = 0;
  int notfound_seen   = 0;
  int expired_seen    = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit is_later(time_ms_t a, time_ms_t b);
    time_ms_t diff;
    diff = a - b;
    return (diff != '0) && (diff < 32'h8000_0000);
  endfunction

  function automatic timer_reply_t make_reply(logic [STAT_W-1:0] status, timer_id_t id,
                                              logic last);
    timer_reply_t r;
    r.status     = status;
    r.expired_id = id;
    r.last       = last;
    return r;
  endfunction

  function automatic void place_timer(timer_id_t id, time_ms_t expiry);
    int pos;
    pos = live_count;
    while (pos > 0 && is_later(slot_expiry[pos-1], expiry)) begin
      slot_expiry[pos] = slot_expiry[pos-1];
      slot_owner[pos]  = slot_owner[pos-1];
      pos--;
    end
    slot_expiry[pos] = expiry;
    slot_owner[pos]  = id;
    live_count++;
  endfunction

  function automatic int find_slot(timer_id_t id);
    for (int i = 0; i < live_count; i++) begin
      if (slot_owner[i] == id) begin
        return i;
      end
    end
    return live_count;
  endfunction

  function automatic void drop_slot(int idx);
    for (int i = idx; i + 1 < live_count; i++) begin
      slot_expiry[i] = slot_expiry[i+1];
      slot_owner[i]  = slot_owner[i+1];
    end
    live_count--;
  endfunction

  // update the shadow table and queue the replies one command produces
  function automatic void apply_timer_cmd(logic [FUNC_W-1:0] func, timer_id_t id,
                                          logic [TMO_W-1:0] tmo, time_ms_t now);
    time_ms_t     expiry;
    int           idx;
    int           n;
    timer_reply_t tail;
    expiry = now + {1'b0, tmo};
    case (func)
      FUNC_ADD: begin
        if (live_count >= TIMER_SLOTS_DEF) begin
          predicted_replies.push_back(make_reply(ST_FULL, '0, 1'b1));
        end else begin
          place_timer(id, expiry);
          predicted_replies.push_back(make_reply(ST_OK, '0, 1'b1));
        end
      end
      FUNC_ADJUST, FUNC_REMOVE: begin
        idx = find_slot(id);
        if (idx >= live_count) begin
          predicted_replies.push_back(make_reply(ST_NOTFOUND, '0, 1'b1));
        end else begin
          drop_slot(idx);
          if (func == FUNC_ADJUST) begin
            place_timer(id, expiry);
          end
          predicted_replies.push_back(make_reply(ST_OK, '0, 1'b1));
        end
      end
      default: begin
        n = 0;
        while (live_count > 0 && n < MAX_RESULTS && !is_later(slot_expiry[0], now)) begin
          predicted_replies.push_back(make_reply(ST_EXPIRED, slot_owner[0], 1'b0));
          drop_slot(0);
          n++;
        end
        if (n == 0) begin
          predicted_replies.push_back(make_reply(ST_NONE, '0, 1'b1));
        end else begin
          tail = predicted_replies.pop_back();
          tail.last = 1'b1;
          predicted_replies.push_back(tail);
        end
      end
    endcase
  endfunction

  task automatic send_cmd(logic [FUNC_W-1:0] func, timer_id_t id, logic [TMO_W-1:0] tmo,
                          time_ms_t now);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.func       = func;
    in_ch.timer_id   = id;
    in_ch.timeout_ms = tmo;
    in_ch.now_ms     = now;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    apply_timer_cmd(func, id, tmo, now);
    cmds_sent++;
    cmd_count[func]++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // receiver backpressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin : result_check
    timer_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (predicted_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected transfer: status %0d id %h last %b",
                   out_ch.status, out_ch.expired_id, out_ch.last);
        end
      end else begin
        want = predicted_replies.pop_front();
        replies_checked++;
        case (want.status)
          ST_FULL:     full_seen++;
          ST_NOTFOUND: notfound_seen++;
          ST_EXPIRED:  expired_seen++;
          default: ;
        endcase
        if (out_ch.status !== want.status || out_ch.expired_id !== want.expired_id ||
            out_ch.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected status %0d id %h last %b, got status %0d id %h last %b",
                     want.status, want.expired_id, want.last,
                     out_ch.status, out_ch.expired_id, out_ch.last);
          end
        end
      end
    end
  end

  task automatic test_directed_cases();
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'h0000_0000);
    send_cmd(FUNC_REMOVE, 16'h0005, 31'h0,        32'h0000_0000);
    send_cmd(FUNC_ADJUST, 16'h0005, 31'h10,       32'h0000_0000);
    send_cmd(FUNC_ADD,    16'h0000, 31'h0,        32'hFFFF_FFF0);
    send_cmd(FUNC_ADD,    16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(FUNC_ADD,    16'h0003, 31'h20,       32'hFFFF_FFF0);
    send_cmd(FUNC_ADD,    16'h0003, 31'h20,       32'hFFFF_FFF0);
    send_cmd(FUNC_ADD,    16'h0009, 31'h10,       32'hFFFF_FFF0);
    send_cmd(FUNC_TICK,   16'hFFFF, 31'h7FFF_FFFF, 32'hFFFF_FFEF);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'hFFFF_FFF0);
    send_cmd(FUNC_ADJUST, 16'h0003, 31'h5,        32'hFFFF_FFF0);
    send_cmd(FUNC_REMOVE, 16'h0003, 31'h0,        32'h0000_0000);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'h0000_0010);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'h8000_0000);
    send_cmd(FUNC_REMOVE, 16'hFFFF, 31'h0,        32'h0000_0000);
    send_cmd(FUNC_ADD,    16'h1234, 31'h7FFF_FFFF, 32'h0000_0000);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'h0000_0000);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'hFFFF_FFFF);
    send_cmd(FUNC_ADD,    16'hAAAA, 31'h2AAA_AAAA, 32'h5555_5555);
    send_cmd(FUNC_ADD,    16'h5555, 31'h5555_5555, 32'hAAAA_AAAA);
    send_cmd(FUNC_ADD,    16'hAAAA, 31'h1,        32'hFFFF_FFFE);
    send_cmd(FUNC_ADJUST, 16'hAAAA, 31'h7FFF_FFFF, 32'h0000_0001);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'hFFFF_FFFF);
    send_cmd(FUNC_TICK,   16'h0000, 31'h0,        32'h8000_0000);
  endtask

  task automatic test_random_traffic(int n_cmds);
    int               pick;
    logic [FUNC_W-1:0] func;
    timer_id_t        id;
    logic [TMO_W-1:0] tmo;
    time_ms_t         now;
    for (int i = 0; i < n_cmds; i++) begin
      pick = $urandom_range(0, 99);
      wall_ms += $urandom_range(0, 40);
      if (pick < 40) begin
        func = FUNC_ADD;
      end else if (pick < 55) begin
        func = FUNC_ADJUST;
      end else if (pick < 70) begin
        func = FUNC_REMOVE;
      end else begin
        func = FUNC_TICK;
      end
      if ($urandom_range(0, 9) == 0) begin
        id = 16'($urandom);
      end else if (func != FUNC_ADD && live_count > 0 && $urandom_range(0, 1) == 1) begin
        id = slot_owner[$urandom_range(0, live_count - 1)];
      end else begin
        id = 16'($urandom_range(0, 7));
      end
      tmo = ($urandom_range(0, 9) == 0) ? 31'($urandom) : 31'($urandom_range(0, 120));
      now = ($urandom_range(0, 19) == 0) ? time_ms_t'($urandom) : wall_ms;
      send_cmd(func, id, tmo, now);
    end
  endtask

  task automatic test_fill_and_drain();
    while (live_count < TIMER_SLOTS_DEF) begin
      wall_ms += $urandom_range(0, 3);
      send_cmd(FUNC_ADD, 16'($urandom), 31'($urandom_range(0, 60)), wall_ms);
    end
    send_cmd(FUNC_ADD, 16'($urandom), 31'($urandom_range(0, 60)), wall_ms);
    send_cmd(FUNC_ADJUST, slot_owner[$urandom_range(0, live_count - 1)],
             31'($urandom_range(0, 60)), wall_ms);
    send_cmd(FUNC_REMOVE, slot_owner[$urandom_range(0, live_count - 1)], 31'h0, wall_ms);
    send_cmd(FUNC_ADD, 16'($urandom), 31'($urandom_range(0, 60)), wall_ms);
    wall_ms += 500;
    send_cmd(FUNC_TICK, 16'($urandom), 31'($urandom), wall_ms);
    send_cmd(FUNC_TICK, 16'($urandom), 31'($urandom), wall_ms);
  endtask

  task automatic set_idling(int in_pct, int out_pct);
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = FUNC_ADD;
    in_ch.timer_id   = '0;
    in_ch.timeout_ms = '0;
    in_ch.now_ms     = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_idling(0, 0);
    test_directed_cases();
    test_random_traffic(10);
    set_idling(50, 0);
    test_random_traffic(10);
    set_idling(0, 50);
    test_random_traffic(10);
    set_idling(22, 22);
    test_fill_and_drain();
    test_random_traffic(10);

    set_idling(0, 0);
    while (predicted_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * TIMER_SLOTS_DEF + 40) @(posedge clk);

    $display("covered %0d commands: %0d add, %0d adjust, %0d remove, %0d tick",
             cmds_sent, cmd_count[FUNC_ADD], cmd_count[FUNC_ADJUST],
             cmd_count[FUNC_REMOVE], cmd_count[FUNC_TICK]);
    $display("checked %0d results: %0d full, %0d not found, %0d expired, %0d mismatches",
             replies_checked, full_seen, notfound_seen, expired_seen, mismatch_count);
    if (mismatch_count == 0 && predicted_replies.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/eot_pkg.sv
hdl/eot_in_if.sv
hdl/eot_out_if.sv
hdl/eot_ram.sv
hdl/expiry_ordered_timer_table.sv
tb/tb_top.sv
